@@ hw/rtl/ranked_insert_table_core_defines.svh @@
// Assertion macros used by the ranked insert table datapath.
`ifndef RANKED_INSERT_TABLE_CORE_DEFINES_SVH
`define RANKED_INSERT_TABLE_CORE_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define RIT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define RIT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/rit_pkg.sv @@
package rit_pkg;

    localparam int DEPTH_DEF = 16;

    localparam int OP_W     = 2;
    localparam int KEY_W    = 16;
    localparam int TAG_W    = 32;
    localparam int RANK_W   = 4;
    localparam int OUT_CW   = 5;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // Read address selection for the table RAM.
    typedef logic [1:0] t_rd_sel;
    localparam t_rd_sel RD_PREV  = 2'd0;  // entry one above the insert position
    localparam t_rd_sel RD_PREV2 = 2'd1;  // entry two above the insert position
    localparam t_rd_sel RD_RANK  = 2'd2;  // entry at the requested rank

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [KEY_W-1:0] tries;
        logic [KEY_W-1:0] hits;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic    take;
        logic    clear;
        logic    place;
        logic    shift;
        logic    cap_rd;
        logic    load_out;
        t_rd_sel rd_sel;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            rd_hit;
        logic            pos_zero;
        logic            pos_one;
        logic            stop;
        logic            out_free;
    } t_sts;

    // True when the stored entry ranks at or above the new key.
    function automatic logic ranks_not_below(t_entry e, logic [KEY_W-1:0] h,
                                             logic [KEY_W-1:0] t);
        ranks_not_below = (e.hits > h) || ((e.hits == h) && (e.tries <= t));
    endfunction

endpackage

@@ hw/rtl/rit_ram.sv @@
module rit_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/rit_ctrl.sv @@
module rit_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rit_pkg::t_sts i_sts,
    output rit_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_KEY0 = 3'd3;
    localparam logic [2:0] S_RDAT = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.rd_sel = rit_pkg::RD_PREV;
        o_in_ready   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                priority if (i_sts.op == rit_pkg::OP_INSERT) begin
                    if (i_sts.pos_zero) begin
                        o_cmd.place = 1'b1;
                        n_state     = S_DONE;
                    end else begin
                        o_cmd.rd_sel = rit_pkg::RD_PREV;
                        n_state      = S_CMP;
                    end
                end else if (i_sts.op == rit_pkg::OP_READ) begin
                    if (i_sts.rd_hit) begin
                        o_cmd.rd_sel = rit_pkg::RD_RANK;
                        n_state      = S_RDAT;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (i_sts.op == rit_pkg::OP_CLEAR) begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_DONE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CMP: begin
                if (i_sts.stop) begin
                    o_cmd.place = 1'b1;
                    n_state     = S_DONE;
                end else begin
                    o_cmd.shift = 1'b1;
                    if (i_sts.pos_one) begin
                        n_state = S_KEY0;
                    end else begin
                        o_cmd.rd_sel = rit_pkg::RD_PREV2;
                    end
                end
            end
            S_KEY0: begin
                o_cmd.place = 1'b1;
                n_state     = S_DONE;
            end
            S_RDAT: begin
                o_cmd.cap_rd = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/rit_dp.sv @@
`include "ranked_insert_table_core_defines.svh"

module rit_dp #(
    parameter int DEPTH = rit_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rit_pkg::t_cmd                 i_cmd,
    output rit_pkg::t_sts                 o_sts,
    input  logic [rit_pkg::OP_W-1:0]      i_opcode,
    input  logic [rit_pkg::KEY_W-1:0]     i_hits,
    input  logic [rit_pkg::KEY_W-1:0]     i_tries,
    input  logic [rit_pkg::TAG_W-1:0]     i_player_tag,
    input  logic [rit_pkg::RANK_W-1:0]    i_read_rank,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_entry_valid,
    output logic [rit_pkg::KEY_W-1:0]     o_out_hits,
    output logic [rit_pkg::KEY_W-1:0]     o_out_tries,
    output logic [rit_pkg::TAG_W-1:0]     o_out_tag,
    output logic [rit_pkg::OUT_CW-1:0]    o_placed_rank,
    output logic [rit_pkg::OUT_CW-1:0]    o_entry_count,
    output logic                          o_dropped
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > rit_pkg::RANK_W) ? CW : rit_pkg::RANK_W;
    localparam int OW = (CW > rit_pkg::OUT_CW) ? CW : rit_pkg::OUT_CW;
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    // Item held for the duration of one operation.
    logic [rit_pkg::OP_W-1:0]   r_op;
    logic [rit_pkg::RANK_W-1:0] r_rank;
    rit_pkg::t_entry            r_key;

    logic [CW-1:0] r_count;
    logic [CW-1:0] r_pos;

    logic [CW-1:0]   r_placed;
    logic            r_drop;
    logic            r_evalid;
    rit_pkg::t_entry r_data;

    logic                       r_ovalid;
    logic                       r_o_evalid;
    rit_pkg::t_entry            r_o_data;
    logic [rit_pkg::OUT_CW-1:0] r_o_placed;
    logic [rit_pkg::OUT_CW-1:0] r_o_count;
    logic                       r_o_drop;

    rit_pkg::t_entry q;
    rit_pkg::t_entry wdata;
    logic            we;
    logic [AW-1:0]   raddr;
    logic [CW-1:0]   pos_m1;
    logic [CW-1:0]   pos_m2;
    logic [XW-1:0]   rank_ext;
    logic [OW-1:0]   placed_ext;
    logic [OW-1:0]   count_ext;

    assign pos_m1   = r_pos - CW'(1);
    assign pos_m2   = r_pos - CW'(2);
    assign rank_ext = XW'(r_rank);

    always_comb begin
        unique case (i_cmd.rd_sel)
            rit_pkg::RD_PREV:  raddr = pos_m1[AW-1:0];
            rit_pkg::RD_PREV2: raddr = pos_m2[AW-1:0];
            rit_pkg::RD_RANK:  raddr = rank_ext[AW-1:0];
            default:           raddr = pos_m1[AW-1:0];
        endcase
    end

    // A write at the position one past the end discards the entry.
    assign we    = (i_cmd.place || i_cmd.shift) && (r_pos != FULL);
    assign wdata = i_cmd.shift ? q : r_key;

    rit_ram #(
        .WIDTH (rit_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_pos[AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pos   <= '0;
        end else begin
            if (i_cmd.take) begin
                r_pos <= r_count;
            end else if (i_cmd.shift) begin
                r_pos <= pos_m1;
            end
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.place && (r_count != FULL)) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_op       <= i_opcode;
            r_rank     <= i_read_rank;
            r_key.hits <= i_hits;
            r_key.tries <= i_tries;
            r_key.tag  <= i_player_tag;
            r_placed   <= FULL;
            r_drop     <= 1'b0;
            r_evalid   <= 1'b0;
            r_data     <= '0;
        end else begin
            if (i_cmd.place) begin
                r_placed <= r_pos;
                r_drop   <= (r_count == FULL);
            end
            if (i_cmd.cap_rd) begin
                r_evalid <= 1'b1;
                r_data   <= q;
            end
        end
    end

    assign placed_ext = OW'(r_placed);
    assign count_ext  = OW'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_evalid <= r_evalid;
            r_o_data   <= r_data;
            r_o_placed <= placed_ext[rit_pkg::OUT_CW-1:0];
            r_o_count  <= count_ext[rit_pkg::OUT_CW-1:0];
            r_o_drop   <= r_drop;
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_entry_valid = r_o_evalid;
    assign o_out_hits    = r_o_data.hits;
    assign o_out_tries   = r_o_data.tries;
    assign o_out_tag     = r_o_data.tag;
    assign o_placed_rank = r_o_placed;
    assign o_entry_count = r_o_count;
    assign o_dropped     = r_o_drop;

    assign o_sts.op       = r_op;
    assign o_sts.rd_hit   = (rank_ext < XW'(r_count));
    assign o_sts.pos_zero = (r_pos == '0);
    assign o_sts.pos_one  = (r_pos == CW'(1));
    assign o_sts.stop     = rit_pkg::ranks_not_below(q, r_key.hits, r_key.tries);
    assign o_sts.out_free = !r_ovalid || i_out_ready;

    `RIT_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= FULL, "entry count exceeds depth")
    `RIT_ASSERT(a_shift_pos, i_clk, i_rst_n, !i_cmd.shift || (r_pos != '0), "shift at rank zero")
    `RIT_ASSERT_NEXT(a_count_inc, i_clk, i_rst_n, i_cmd.place && (r_count != FULL), r_count == $past(r_count) + CW'(1), "insert did not grow the table")
    `RIT_ASSERT_NEXT(a_load_valid, i_clk, i_rst_n, i_cmd.load_out, r_ovalid, "result not presented after load")

endmodule

@@ hw/rtl/ranked_insert_table_core.sv @@
// Ranked insert table: keeps up to DEPTH entries (hits, tries, player tag) in
// rank order, more hits first and, on equal hits, fewer tries first. An
// insert lands after every entry with an equal key, so ties keep their
// arrival order; when the table is full the lowest-ranked entry, possibly
// the new one, is dropped and the result says so. Every accepted item gives
// exactly one result transfer. The entries live in a single RAM with one
// write and one registered read port, and an insert walks up from the end
// of the table one entry per cycle, comparing and moving entries down.
// Each item is decoded after acceptance: a clear or an unused opcode then
// finishes, a read of a rank below the count captures that entry, one at
// or past the count finishes at once, an insert into an empty table places
// the key and any other insert moves entries down, at most DEPTH, until the
// key is placed. The controller goes back to idle as the result is loaded,
// so the next item can be accepted in the cycle after that. Only one item
// is in flight at a time, but a finished result sits in an output register
// so the next item can be accepted while it waits. No clearing pass is
// needed after reset: entries at or beyond the count are never read.
module ranked_insert_table_core #(
    parameter int DEPTH = rit_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // Fields from bit 0 up: hits[16], tries[16], player_tag[32],
    // read_rank[4], zero fill[4].
    input  logic [71:0] s_tdata,
    // Fields from bit 0 up: opcode[2].
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // Fields from bit 0 up: out_hits[16], out_tries[16], out_tag[32],
    // placed_rank[5], entry_count[5], dropped[1], zero fill[5].
    output logic [79:0] m_tdata,
    // Fields from bit 0 up: entry_valid[1].
    output logic        m_tuser
);

    rit_pkg::t_cmd cmd;
    rit_pkg::t_sts sts;

    logic                          entry_valid;
    logic [rit_pkg::KEY_W-1:0]     out_hits;
    logic [rit_pkg::KEY_W-1:0]     out_tries;
    logic [rit_pkg::TAG_W-1:0]     out_tag;
    logic [rit_pkg::OUT_CW-1:0]    placed_rank;
    logic [rit_pkg::OUT_CW-1:0]    entry_count;
    logic                          dropped;

    // The controller sequences each operation; it sees only status and valid.
    rit_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .o_in_ready (s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // The datapath holds the table, the count, the item and the result.
    rit_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_opcode      (s_tuser),
        .i_hits        (s_tdata[15:0]),
        .i_tries       (s_tdata[31:16]),
        .i_player_tag  (s_tdata[63:32]),
        .i_read_rank   (s_tdata[67:64]),
        .i_out_ready   (m_tready),
        .o_out_valid   (m_tvalid),
        .o_entry_valid (entry_valid),
        .o_out_hits    (out_hits),
        .o_out_tries   (out_tries),
        .o_out_tag     (out_tag),
        .o_placed_rank (placed_rank),
        .o_entry_count (entry_count),
        .o_dropped     (dropped)
    );

    assign m_tdata = {5'b00000, dropped, entry_count, placed_rank, out_tag,
                      out_tries, out_hits};
    assign m_tuser = entry_valid;

endmodule
